// ----- hw/rtl/mau_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared operation codes, status codes and the reset modulus.
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int unsigned MOD_WIDTH = 32;
   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_POW = 3'd3,
      OP_INV = 3'd4,
      OP_DIV = 3'd5,
      OP_RSV6 = 3'd6,
      OP_RSV7 = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_NOINV = 2'd2,
      ST_RSV   = 2'd3
   } status_type;

   // Request and done handshake between the sequencer and a serial unit.
   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

endpackage

// ----- hw/rtl/mau_mulmod.sv -----
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Computes a*b mod m one bit of b per cycle (shift and add, MSB first).
// ----------------------------------------------------------------------------
module mau_mulmod #(
   parameter int unsigned W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mau_pkg::unit_ctl_type ctl,
   input  logic [W-1:0]         mul_a,
   input  logic [W-1:0]         mul_b,
   input  logic [W-1:0]         mul_m,
   output mau_pkg::unit_sts_type sts,
   output logic [W-1:0]         mul_p
);

   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  bsh_ff, bsh_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    dbl, dbl_red, add, add_red;

   always_comb begin
      // acc < m, so 2*acc < 2m and one subtraction reduces it.
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, mul_m}) ? dbl - {1'b0, mul_m} : dbl;
      add     = dbl_red + (bsh_ff[W-1] ? {1'b0, mul_a} : {(W+1){1'b0}});
      add_red = (add >= {1'b0, mul_m}) ? add - {1'b0, mul_m} : add;
      acc_in  = acc_ff;
      bsh_in  = bsh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         acc_in  = '0;
         bsh_in  = mul_b;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = add_red[W-1:0];
         bsh_in = {bsh_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      bsh_ff <= bsh_in;
   end

   assign sts.done = done_ff;
   assign mul_p    = acc_ff;

endmodule

// ----- hw/rtl/mau_inverse.sv -----
// ----------------------------------------------------------------------------
// Serial modular inverse
// Extended Euclid by shift and subtract, one step per cycle.
// Handles any modulus; coefficients are kept reduced modulo m.
// ----------------------------------------------------------------------------
module mau_inverse #(
   parameter int unsigned W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mau_pkg::unit_ctl_type ctl,
   input  logic [W-1:0]         inv_v,
   input  logic [W-1:0]         inv_m,
   output mau_pkg::unit_sts_type sts,
   output logic                 inv_ok,
   output logic [W-1:0]         inv_r
);

   // Each remainder is found by subtracting the largest aligned multiple
   // r1*2^k from r0, and t0 loses t1*2^k mod m in the same step. Once r0
   // drops below r1 the pairs are swapped, as in the textbook loop.

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALIGN,
      S_DIV,
      S_NEXT,
      S_DONE
   } state_type;

   state_type     state_ff, state_in;
   logic [W-1:0]  r0_ff, r0_in, r1_ff, r1_in;
   logic [W-1:0]  t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0]  d_ff, d_in;      // shifted divisor r1 << k
   logic [W-1:0]  td_ff, td_in;    // t1 * 2^k mod m
   logic          done_ff, done_in;
   logic          ok_ff, ok_in;
   logic [W:0]    sub_t, td_half;
   logic [W:0]    m_ext;

   assign m_ext = {1'b0, inv_m};

   always_comb begin
      state_in = state_ff;
      r0_in = r0_ff; r1_in = r1_ff; t0_in = t0_ff; t1_in = t1_ff;
      d_in = d_ff; td_in = td_ff;
      done_in = 1'b0;
      ok_in = ok_ff;
      sub_t = '0;
      td_half = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               r0_in = inv_m; r1_in = inv_v;
               t0_in = '0;    t1_in = W'(1) ;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (r1_ff == '0) begin
               ok_in = (r0_ff == W'(1));
               state_in = S_DONE;
            end else if (r0_ff < r1_ff) begin
               // Quotient finished: rotate (r0,r1)<=(r1,r0), (t0,t1)<=(t1,t0).
               r0_in = r1_ff; r1_in = r0_ff;
               t0_in = t1_ff; t1_in = t0_ff;
            end else begin
               d_in  = r1_ff;
               td_in = t1_ff;
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            // Grow d = r1*2^k while 2d <= r0; td tracks t1*2^k mod m.
            if (!d_ff[W-1] && ({d_ff, 1'b0} <= {1'b0, r0_ff})) begin
               d_in = {d_ff[W-2:0], 1'b0};
               td_half = {td_ff, 1'b0};
               td_in = (td_half >= m_ext) ? W'(td_half - m_ext) : td_half[W-1:0];
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Subtract one aligned multiple, then realign from scratch.
            r0_in = r0_ff - d_ff;
            sub_t = {1'b0, t0_ff} + ((t0_ff >= td_ff) ? {(W+1){1'b0}} : m_ext)
                    - {1'b0, td_ff};
            t0_in = sub_t[W-1:0];
            state_in = S_NEXT;
         end
         S_DONE: begin
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in;
      d_ff <= d_in; td_ff <= td_in;
      ok_ff <= ok_in;
   end

   assign sts.done = done_ff;
   assign inv_ok   = ok_ff;
   // t0 after the final rotation is the Bezout coefficient of v, kept mod m.
   assign inv_r    = t0_ff;

endmodule

// ----- hw/rtl/modular_arithmetic_unit.sv -----
// Add, sub, unknown operations and range errors are answered straight from the
// check state; mul runs one serial multiply; pow runs 64 plus the number of
// set exponent bits multiplies; inverse runs the subtractive Euclid loop, and
// divide adds one multiply after it.
// One item is worked on at a time; the next is taken once its result sits in
// the output register. Synchronous active-high reset sets modulus 1000000007.
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Sequencer around a bit-serial modular multiplier and a serial inverse.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit #(
   parameter int unsigned OPERAND_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_modulus,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_value,
   output logic [1:0]  rsp_status
);

   localparam int unsigned W = OPERAND_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_MUL, S_POW_SQ, S_POW_MUL, S_INV, S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [31:0]           mod_ff, mod_in;
   mau_pkg::op_type       op_ff, op_in;
   logic [W-1:0]          a_ff, a_in, b_ff, b_in;
   logic [W-1:0]          ma_ff, ma_in, mb_ff, mb_in;
   logic [63:0]           e_ff, e_in;
   logic [6:0]            bit_ff, bit_in;
   logic                  b_ok_ff, b_ok_in;
   logic [31:0]           res_ff, res_in;
   mau_pkg::status_type   st_ff, st_in;
   logic                  mul_go_ff, mul_go_in;
   logic                  inv_go_ff, inv_go_in;
   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_value_ff, out_value_in;
   mau_pkg::status_type   out_status_ff, out_status_in;
   mau_pkg::unit_ctl_type mctl, ictl;
   mau_pkg::unit_sts_type msts, ists;
   logic [W-1:0]          mp, ir, m_w;
   logic                  iok;
   logic [W:0]            sum;

   assign m_w = mod_ff[W-1:0];
   assign csr_ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign mctl.start = mul_go_ff;
   assign ictl.start = inv_go_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_status = out_status_ff;

   mau_mulmod #(.W(W)) u_mul (
      .clock(clock), .reset(reset), .ctl(mctl),
      .mul_a(ma_ff), .mul_b(mb_ff), .mul_m(m_w), .sts(msts), .mul_p(mp)
   );

   mau_inverse #(.W(W)) u_inv (
      .clock(clock), .reset(reset), .ctl(ictl),
      .inv_v((op_ff == mau_pkg::OP_DIV) ? b_ff : a_ff), .inv_m(m_w),
      .sts(ists), .inv_ok(iok), .inv_r(ir)
   );

   always_comb sum = {1'b0, a_ff} + {1'b0, b_ff};

   always_comb begin
      state_in      = state_ff;
      mod_in        = mod_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      e_in          = e_ff;
      bit_in        = bit_ff;
      b_ok_in       = b_ok_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      mul_go_in     = 1'b0;
      inv_go_in     = 1'b0;
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      if (csr_valid && csr_ready) mod_in = csr_modulus;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               op_in   = mau_pkg::op_type'(req_type);
               a_in    = req_operand_a[W-1:0];
               b_in    = req_operand_b[W-1:0];
               e_in    = req_operand_b;
               b_ok_in = (req_operand_b < {{(64-W){1'b0}}, m_w});
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_in   = '0;
            st_in    = mau_pkg::ST_OK;
            state_in = S_OUT;
            if (op_ff == mau_pkg::OP_RSV6 || op_ff == mau_pkg::OP_RSV7) begin
               // Unknown operations answer zero with an ok status.
            end else if (m_w < W'(2) || a_ff >= m_w ||
                         (!b_ok_ff && op_ff != mau_pkg::OP_POW &&
                          op_ff != mau_pkg::OP_INV)) begin
               st_in = mau_pkg::ST_RANGE;
            end else begin
               unique case (op_ff)
                  mau_pkg::OP_ADD:
                     res_in = 32'((sum >= {1'b0, m_w}) ? sum - {1'b0, m_w} : sum);
                  mau_pkg::OP_SUB:
                     res_in = 32'((a_ff >= b_ff) ? a_ff - b_ff : a_ff + (m_w - b_ff));
                  mau_pkg::OP_MUL: begin
                     ma_in = a_ff; mb_in = b_ff;
                     mul_go_in = 1'b1; state_in = S_MUL;
                  end
                  mau_pkg::OP_POW: begin
                     bit_in = 7'd64;
                     ma_in = W'(1); mb_in = W'(1);
                     mul_go_in = 1'b1; state_in = S_POW_SQ;
                  end
                  default: begin
                     inv_go_in = 1'b1; state_in = S_INV;
                  end
               endcase
            end
         end
         S_MUL: begin
            if (msts.done) begin
               res_in = 32'(mp); state_in = S_OUT;
            end
         end
         S_POW_SQ: begin
            if (msts.done) begin
               // Square done; multiply by the base when this exponent bit is set.
               if (e_ff[63]) begin
                  ma_in = mp; mb_in = a_ff;
                  mul_go_in = 1'b1; state_in = S_POW_MUL;
               end else if (bit_ff == 7'd1) begin
                  res_in = 32'(mp); state_in = S_OUT;
               end else begin
                  ma_in = mp; mb_in = mp;
                  e_in = {e_ff[62:0], 1'b0}; bit_in = bit_ff - 7'd1;
                  mul_go_in = 1'b1;
               end
            end
         end
         S_POW_MUL: begin
            if (msts.done) begin
               if (bit_ff == 7'd1) begin
                  res_in = 32'(mp); state_in = S_OUT;
               end else begin
                  ma_in = mp; mb_in = mp;
                  e_in = {e_ff[62:0], 1'b0}; bit_in = bit_ff - 7'd1;
                  mul_go_in = 1'b1; state_in = S_POW_SQ;
               end
            end
         end
         S_INV: begin
            if (ists.done) begin
               if (!iok) begin
                  st_in = mau_pkg::ST_NOINV; state_in = S_OUT;
               end else if (op_ff == mau_pkg::OP_INV) begin
                  res_in = 32'(ir); state_in = S_OUT;
               end else begin
                  ma_in = a_ff; mb_in = ir;
                  op_in = mau_pkg::OP_MUL;
                  mul_go_in = 1'b1; state_in = S_MUL;
               end
            end
         end
         S_OUT: begin
            // The output register is free, or its item leaves at this edge.
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in  = 1'b1;
               out_value_in  = res_ff;
               out_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mod_ff       <= mau_pkg::MODULUS_RESET;
         out_valid_ff <= 1'b0;
         mul_go_ff    <= 1'b0;
         inv_go_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         out_valid_ff <= out_valid_in;
         mul_go_ff    <= mul_go_in;
         inv_go_ff    <= inv_go_in;
      end
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      e_ff          <= e_in;
      bit_ff        <= bit_in;
      b_ok_ff       <= b_ok_in;
      res_ff        <= res_in;
      st_ff         <= st_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

endmodule

// ----- hw/rtl/mau_checker.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Port-level properties of the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module mau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_value,
   input logic [1:0]  rsp_status
);

   ap_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value) &&
                                 $stable(rsp_status))
      else $error("result changed while stalled");

   ap_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mau_pkg::ST_OK |-> rsp_result_value == 32'd0)
      else $error("error result is not zero");

   ap_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != mau_pkg::ST_RSV)
      else $error("bad status code");

   ap_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while the previous one is being worked on");

endmodule

bind modular_arithmetic_unit mau_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_result_value(rsp_result_value), .rsp_status(rsp_status)
);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives operation items through the request channel under several moduli,
// predicts each result in a scoreboard and checks it against the response
// channel, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [31:0]         value;
      mau_pkg::status_type status;
   } mau_result_type;

   class mau_scoreboard;
      logic [31:0] modulus;
      mau_result_type results_due[$];
      int unsigned failures;

      function new();
         modulus  = mau_pkg::MODULUS_RESET;
         failures = 0;
      endfunction

      function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
         logic [63:0] acc;
         acc = 64'd1 % m;
         for (int i = 63; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (e[i]) acc = (acc * base) % m;
         end
         return acc;
      endfunction

      // Returns 0 when the value shares a factor with the modulus.
      function bit inv_mod(logic [63:0] v, logic [63:0] m, output logic [63:0] inv);
         longint r0, r1, t0, t1, q, r2, t2;
         r0 = m; r1 = v; t0 = 0; t1 = 1; inv = 0;
         while (r1 != 0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            t2 = t0 - q * t1;
            r0 = r1; r1 = r2;
            t0 = t1; t1 = t2;
         end
         if (r0 != 1) return 0;
         t0 = t0 % longint'(m);
         if (t0 < 0) t0 = t0 + longint'(m);
         inv = t0;
         return 1;
      endfunction

      function void note_item(mau_pkg::op_type op, logic [31:0] a, logic [63:0] b);
         mau_result_type r;
         logic [63:0] m, inv, res;
         bit need_b;
         m = {32'd0, modulus};
         res = 0;
         r.status = mau_pkg::ST_OK;
         if (op != mau_pkg::OP_RSV6 && op != mau_pkg::OP_RSV7) begin
            need_b = (op != mau_pkg::OP_POW) && (op != mau_pkg::OP_INV);
            if (m < 2 || a >= m || (need_b && b >= m)) begin
               r.status = mau_pkg::ST_RANGE;
            end else begin
               case (op)
                  mau_pkg::OP_ADD: res = (a + b) % m;
                  mau_pkg::OP_SUB: res = (a + m - b) % m;
                  mau_pkg::OP_MUL: res = (a * b) % m;
                  mau_pkg::OP_POW: res = pow_mod(a, b, m);
                  mau_pkg::OP_INV: begin
                     if (inv_mod(a, m, inv)) res = inv;
                     else r.status = mau_pkg::ST_NOINV;
                  end
                  default: begin
                     if (inv_mod(b, m, inv)) res = (a * inv) % m;
                     else r.status = mau_pkg::ST_NOINV;
                  end
               endcase
            end
         end
         r.value = res[31:0];
         results_due = {results_due, r};
      endfunction

      function void check_result(logic [31:0] value, logic [1:0] status);
         mau_result_type e;
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result value=%0d status=%0d", $time, value, status);
            failures++;
            return;
         end
         e = results_due.pop_front();
         if (value !== e.value) begin
            $display("%0t: value mismatch expected=%0d actual=%0d", $time, e.value, value);
            failures++;
         end
         if (status !== e.status) begin
            $display("%0t: status mismatch expected=%0d actual=%0d", $time, e.status, status);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_modulus;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [31:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_result_value;
   logic [1:0]  rsp_status;

   mau_scoreboard sb = new();
   bit quiet = 0;
   int unsigned cycles = 0;
   int stall_left = 0;

   modular_arithmetic_unit DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_modulus(csr_modulus),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value), .rsp_status(rsp_status)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_result_value, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Leaves valid high after acceptance so back-to-back items need no toggle.
   task automatic send_item(mau_pkg::op_type op, logic [31:0] a, logic [63:0] b);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      sb.note_item(op, a, b);
   endtask

   task automatic write_modulus(logic [31:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.modulus = value;
   endtask

   function automatic logic [63:0] below_mod(logic [31:0] m);
      if (m < 2) return {$urandom, $urandom};
      return {$urandom, $urandom} % m;
   endfunction

   task automatic random_items(int count);
      mau_pkg::op_type op;
      logic [31:0] a;
      logic [63:0] b;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 15) == 0) ? mau_pkg::op_type'($urandom_range(6, 7))
                                           : mau_pkg::op_type'($urandom_range(0, 5));
         a = ($urandom_range(0, 9) == 0) ? $urandom : 32'(below_mod(sb.modulus));
         if (op == mau_pkg::OP_POW || $urandom_range(0, 9) == 0) b = {$urandom, $urandom};
         else b = below_mod(sb.modulus);
         // A few pows with tiny exponents keep the exponent corner busy.
         if (op == mau_pkg::OP_POW && $urandom_range(0, 4) == 0) b = 64'($urandom_range(0, 3));
         send_item(op, a, b);
      end
   endtask

   task automatic directed_items();
      logic [31:0] m1;
      m1 = sb.modulus - 1;
      send_item(mau_pkg::OP_ADD, m1, m1);
      send_item(mau_pkg::OP_ADD, 0, 0);
      send_item(mau_pkg::OP_SUB, 0, m1);
      send_item(mau_pkg::OP_SUB, m1, m1);
      send_item(mau_pkg::OP_MUL, m1, m1);
      send_item(mau_pkg::OP_POW, 0, 0);
      send_item(mau_pkg::OP_POW, m1, 0);
      send_item(mau_pkg::OP_POW, 2, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(mau_pkg::OP_POW, m1, 64'h8000_0000_0000_0001);
      send_item(mau_pkg::OP_INV, 0, 0);
      send_item(mau_pkg::OP_INV, 1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(mau_pkg::OP_INV, m1, 5);
      send_item(mau_pkg::OP_DIV, 7, 0);
      send_item(mau_pkg::OP_DIV, m1, 3);
      send_item(mau_pkg::OP_ADD, sb.modulus, 0);
      send_item(mau_pkg::OP_MUL, 1, {32'd0, sb.modulus});
      send_item(mau_pkg::OP_SUB, 1, 64'hFFFF_FFFF_0000_0000);
      send_item(mau_pkg::OP_DIV, 32'hFFFF_FFFF, 0);
      send_item(mau_pkg::OP_POW, 32'hFFFF_FFFF, 3);
      send_item(mau_pkg::OP_RSV6, 5, 5);
      send_item(mau_pkg::OP_RSV7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   initial begin
      reset         <= 1'b1;
      csr_valid     <= 1'b0;
      csr_modulus   <= '0;
      req_valid     <= 1'b0;
      req_type      <= mau_pkg::OP_ADD;
      req_operand_a <= '0;
      req_operand_b <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();
      random_items(14);
      write_modulus(32'hFFFF_FFFF);
      directed_items();
      random_items(10);
      write_modulus(32'd1000000);
      random_items(12);
      write_modulus(32'd2);
      random_items(8);
      write_modulus(32'd0);
      random_items(5);
      write_modulus(32'd1);
      random_items(5);
      write_modulus(32'd97);
      random_items(14);
      write_modulus(32'hFFFF_FFFB);
      random_items(12);
      quiet = 1;
      write_modulus(32'd1000000007);
      random_items(16);

      req_valid <= 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.failures == 0 && sb.results_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
